### design/hdmt_pkg.sv
`default_nettype none
package hdmt_pkg;

  localparam int ADDR_W  = 64;
  localparam int BYTES_W = 32;
  localparam int SLOT_W  = 4;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DREAD  = 5'b00100,
    S_FINISH = 5'b01000,
    S_SPARE  = 5'b10000
  } hdmt_state_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } hdmt_req_t;

  // payload half of an entry; the tag lives in its own RAM
  typedef struct packed {
    logic [ADDR_W-1:0]  dev;
    logic [BYTES_W-1:0] bytes;
    logic               own;
  } hdmt_entry_t;

endpackage
`default_nettype wire

### design/hdmt_ram.sv
`default_nettype none
module hdmt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/host_device_mapping_table.sv
`default_nettype none
// Host-to-device mapping table, fully associative, round-robin replacement.
// Request channel: drive req_type and the payload with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// An insert (req_type 0) writes the mapping into the first entry that is
// empty or holds the same host address, else into the entry at the
// round-robin pointer, and always raises copy_valid; an owned occupied entry
// that is overwritten comes back on free_valid/free_addr. A lookup
// (req_type 1) returns hit, found_device and slot_used.
// Result channel: one result per request, on the result ports for exactly
// one cycle with done high; the receiver cannot hold it off.
// The scan stops at the first qualifying entry, or at the last entry when
// no entry qualifies. The tag RAM is scanned one entry per cycle through
// its single read port, followed by one data RAM read in S_DREAD and a
// write-back in S_FINISH, from which done is registered. A new request
// may be taken in the cycle done is high.
// Reset (rst, synchronous) empties every entry through per-entry valid
// flops and clears the insert pointer; no clearing pass is needed.
module host_device_mapping_table
  import hdmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                req_type,
  input  wire logic [ADDR_W-1:0]   host_addr,
  input  wire logic [ADDR_W-1:0]   device_addr,
  input  wire logic [BYTES_W-1:0]  byte_count,
  input  wire logic                owned,
  output logic                     done,
  output logic                     hit,
  output logic      [ADDR_W-1:0]   found_device,
  output logic                     free_valid,
  output logic      [ADDR_W-1:0]   free_addr,
  output logic                     copy_valid,
  output logic      [SLOT_W-1:0]   slot_used
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = $bits(hdmt_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  hdmt_state_t state;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         ptr;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     cmp_valid;
  logic                     tag_v;
  logic [IDX_W-1:0]         slot;
  logic                     found;
  logic                     occupied;

  // latched request
  logic                     req_lookup;
  logic [ADDR_W-1:0]        host_r;
  hdmt_entry_t              wr_entry;

  logic [ADDR_W-1:0]        tag_q;
  logic [ADDR_W-1:0]        tag_eff;
  logic [ENT_W-1:0]         data_q;
  hdmt_entry_t              rd_entry;
  logic                     match;
  logic                     write_en;
  logic [IDX_W+SLOT_W-1:0]  slot_wide;

  assign busy      = (state != S_IDLE);
  assign tag_eff   = tag_v ? tag_q : '0;
  assign rd_entry  = hdmt_entry_t'(data_q);
  assign write_en  = (state == S_FINISH) && !req_lookup;
  assign slot_wide = {{SLOT_W{1'b0}}, slot};

  always_comb begin
    if (req_lookup) begin
      match = (host_r != '0) && (tag_eff == host_r);
    end else begin
      match = (tag_eff == '0) || (tag_eff == host_r);
    end
  end

  hdmt_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (slot),
    .wdata (host_r),
    .raddr (scan_idx),
    .rdata (tag_q)
  );

  hdmt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (write_en),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (slot),
    .rdata (data_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      ptr       <= '0;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      done  <= 1'b0;
      tag_v <= valid[scan_idx];
      case (state)
        S_IDLE: begin
          if (start) begin
            req_lookup     <= (req_type == REQ_LOOKUP);
            host_r         <= host_addr;
            wr_entry.dev   <= device_addr;
            wr_entry.bytes <= byte_count;
            wr_entry.own   <= owned;
            scan_idx       <= '0;
            cmp_valid      <= 1'b0;
            state          <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= 1'b1;
          cmp_idx   <= scan_idx;
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (cmp_valid && match) begin
            slot     <= cmp_idx;
            found    <= 1'b1;
            occupied <= (tag_eff != '0);
            state    <= S_DREAD;
          end else if (cmp_valid && (cmp_idx == LAST_IDX)) begin
            // no qualifying entry: an insert replaces at the pointer,
            // and every entry is occupied at this point
            slot     <= ptr;
            found    <= 1'b0;
            occupied <= 1'b1;
            state    <= S_DREAD;
          end
        end
        S_DREAD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          done <= 1'b1;
          if (req_lookup) begin
            hit          <= found;
            found_device <= found ? rd_entry.dev : '0;
            slot_used    <= found ? slot_wide[SLOT_W-1:0] : '0;
            free_valid   <= 1'b0;
            free_addr    <= '0;
            copy_valid   <= 1'b0;
          end else begin
            hit          <= 1'b0;
            found_device <= '0;
            slot_used    <= slot_wide[SLOT_W-1:0];
            free_valid   <= occupied && rd_entry.own;
            free_addr    <= (occupied && rd_entry.own) ? rd_entry.dev : '0;
            copy_valid   <= 1'b1;
            valid[slot]  <= 1'b1;
            ptr          <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("result strobe without a write-back cycle");

  a_finish_gives_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |=> (done && !busy))
    else $error("write-back cycle not followed by a result");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_SCAN))
    else $error("accepted request did not start a scan");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && copy_valid))
    else $error("result marked both as lookup hit and insert");

  a_free_on_insert: assert property (@(posedge clk) disable iff (rst)
    (done && free_valid) |-> copy_valid)
    else $error("free reported on a lookup");
`endif

endmodule
`default_nettype wire
